>>> design/b64dec_pkg.sv
package b64dec_pkg;

    // character codes with special meaning
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_VT  = 8'h0B;
    localparam logic [7:0] CHAR_FF  = 8'h0C;
    localparam logic [7:0] CHAR_EQ  = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // sextet values of the two symbol characters
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    // stop reason codes
    typedef enum logic [2:0] {
        STOP_NONE    = 3'd0,
        STOP_END     = 3'd1,
        STOP_BADCHAR = 3'd2,
        STOP_BADPAD  = 3'd3,
        STOP_BADEND  = 3'd4
    } stop_t;

    // one result transaction
    typedef struct packed {
        logic        success;
        logic        message_done;
        stop_t       stop_reason;
        logic        consumed;
        logic        byte_valid;
        logic [7:0]  out_byte;
    } result_t;

    // map a character to {bad, sextet}
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = {1'b1, 6'd0};
        if (c inside {[8'h41:8'h5A]}) begin
            r = {1'b0, 6'(c - 8'h41)};
        end else if (c inside {[8'h61:8'h7A]}) begin
            r = {1'b0, 6'(c - 8'h47)};
        end else if (c inside {[8'h30:8'h39]}) begin
            r = {1'b0, 6'(c + 8'h04)};
        end else if (c == CHAR_PLUS) begin
            r = {1'b0, SEXTET_PLUS};
        end else if (c == CHAR_SLASH) begin
            r = {1'b0, SEXTET_SLASH};
        end
        return r;
    endfunction

    // mask of the low n bits of the bit buffer
    function automatic logic [5:0] low_mask(input logic [2:0] n);
        logic [7:0] m;
        m = (8'd1 << n) - 8'd1;
        return m[5:0];
    endfunction

endpackage

>>> design/base64_lenient_stream_decoder_unit.sv
// path: an accepted character is held in the input register, decoded combinationally, and its result
// is captured in the result register, from which it is presented on the master side
// throughput: one character per cycle unless m_tready stalls the result stage; the decode step
// between the input register and the result register is combinational
// reset: aresetn low clears both stage valids and the decoder state
module base64_lenient_stream_decoder_unit import b64dec_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte, byte_valid, consumed, stop_reason, success, 2'b0
    output logic        m_tlast    // message_done
);

    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       out_vld_reg;
    result_t    out_res_reg;
    result_t    res;
    logic       advance;
    logic       fire;

    // handshake: the result stage frees when empty or being taken
    assign advance  = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    b64dec_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .char_in (in_char_reg),
        .is_last (in_last_reg),
        .result  (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_res_reg.message_done;
    assign m_tdata  = {2'b00, out_res_reg.success, out_res_reg.stop_reason,
                       out_res_reg.consumed, out_res_reg.byte_valid, out_res_reg.out_byte};

endmodule

>>> design/b64dec_core.sv
module b64dec_core import b64dec_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] char_in,
    input  logic       is_last,
    output result_t    result
);

    logic [5:0] buf_reg, buf_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pad_reg, pad_next;
    logic       halted_reg, halted_next;
    logic       wrote_reg, wrote_next;

    logic [2:0]  cnt_pad;
    logic [6:0]  sx;
    logic [11:0] acc;
    logic [3:0]  n;

    // decode one character against the current state
    always_comb begin
        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        pad_next    = pad_reg;
        halted_next = halted_reg;
        wrote_next  = wrote_reg;
        cnt_pad     = cnt_reg - 3'd2;
        sx          = sextet_of(char_in);
        acc         = {buf_reg, sx[5:0]};
        n           = {1'b0, cnt_reg} + 4'd6;
        result      = '0;
        result.stop_reason  = STOP_NONE;
        result.message_done = is_last;

        if (!halted_reg) begin
            result.consumed = 1'b1;
            if (char_in inside {CHAR_CR, CHAR_LF, CHAR_VT, CHAR_FF}) begin
                // whitespace skipped
            end else if (char_in == CHAR_EQ && !pad_reg && cnt_reg == 3'd0) begin
                result.consumed    = 1'b0;
                result.stop_reason = STOP_END;
                halted_next        = 1'b1;
            end else if (char_in == CHAR_EQ && !pad_reg &&
                         (cnt_reg > 3'd4 || (buf_reg & low_mask(cnt_reg)) != 6'd0)) begin
                result.stop_reason = STOP_BADEND;
                halted_next        = 1'b1;
            end else if (pad_reg || char_in == CHAR_EQ) begin
                pad_next = 1'b1;
                if (char_in != CHAR_EQ) begin
                    result.stop_reason = STOP_BADPAD;
                    halted_next        = 1'b1;
                end else begin
                    cnt_next = cnt_pad;
                    buf_next = buf_reg & low_mask(cnt_pad);
                    if (cnt_pad == 3'd0) begin
                        result.stop_reason = STOP_END;
                        halted_next        = 1'b1;
                    end
                end
            end else if (sx[6]) begin
                result.stop_reason = STOP_BADCHAR;
                halted_next        = 1'b1;
            end else begin
                // shift in six bits, take a byte once eight are pending
                if (n >= 4'd8) begin
                    n                 = n - 4'd8;
                    result.out_byte   = 8'(acc >> n);
                    result.byte_valid = 1'b1;
                    wrote_next        = 1'b1;
                end
                cnt_next = n[2:0];
                buf_next = acc[5:0] & low_mask(n[2:0]);
            end
        end

        // end of message: report and clear
        if (is_last) begin
            result.success = wrote_next && cnt_next == 3'd0;
            buf_next    = '0;
            cnt_next    = '0;
            pad_next    = 1'b0;
            halted_next = 1'b0;
            wrote_next  = 1'b0;
        end
    end

    // decoder state, advanced once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg    <= '0;
            cnt_reg    <= '0;
            pad_reg    <= 1'b0;
            halted_reg <= 1'b0;
            wrote_reg  <= 1'b0;
        end else if (fire) begin
            buf_reg    <= buf_next;
            cnt_reg    <= cnt_next;
            pad_reg    <= pad_next;
            halted_reg <= halted_next;
            wrote_reg  <= wrote_next;
        end
    end

endmodule

>>> design/b64dec_checker.sv
module b64dec_checker import b64dec_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // success only on the final transaction of a message
    a_success_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[13] |-> m_tlast)
        else $error("success outside end of message");

    // no byte means a zero data byte
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'd0)
        else $error("data byte without byte_valid");

    // a byte comes only from a consumed character with no stop
    a_byte_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[9] && m_tdata[12:10] == STOP_NONE)
        else $error("byte from an unconsumed or stopping character");

    // stop reason stays within the defined codes
    a_stop_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[12:10] == STOP_NONE || m_tdata[12:10] == STOP_END ||
            m_tdata[12:10] == STOP_BADCHAR || m_tdata[12:10] == STOP_BADPAD ||
            m_tdata[12:10] == STOP_BADEND)
        else $error("undefined stop reason");

endmodule

bind base64_lenient_stream_decoder_unit b64dec_checker u_b64dec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
